@@ hdl/osct_pkg.sv @@
package osct_pkg;

    // Tree geometry
    localparam int UNIVERSE = 1024;
    localparam int LEVELS   = $clog2(UNIVERSE);
    localparam int POS_W    = LEVELS;
    localparam int RANK_W   = LEVELS + 1;
    localparam int CNT_W    = LEVELS + 1;
    localparam int ADDR_W   = LEVELS + 1;
    localparam int DEPTH    = 2 ** ADDR_W;
    localparam int LVL_W    = $clog2(LEVELS + 2);

    // Operation and status codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;
    localparam logic ST_FOUND  = 1'b0;
    localparam logic ST_ERROR  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [POS_W-1:0]  position;
        logic [RANK_W-1:0] rank;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0] found_position;
        logic             status;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_LEAF,
        S_INS_CHK,
        S_INS_UPD,
        S_QRY_ROOT,
        S_QRY_CHK,
        S_QRY_WALK
    } t_state;

    // Read address source
    typedef enum logic [2:0] {
        RD_LEAF,
        RD_PATH,
        RD_ROOT,
        RD_CHILD,
        RD_NEXT
    } t_rd_src;

    // Controller to datapath
    typedef struct packed {
        logic    cap;
        logic    clr_wr;
        logic    inc_wr;
        logic    rd_en;
        t_rd_src rd_src;
        logic    lvl_inc;
        logic    walk_step;
        logic    res_err;
        logic    res_ok;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic leaf_set;
        logic root_bad;
        logic lvl_more;
        logic walk_last;
    } t_stat;

endpackage

@@ hdl/osct_ram.sv @@
module osct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/osct_ctrl.sv @@
module osct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_op,
    input  osct_pkg::t_stat i_stat,
    output osct_pkg::t_cmd  o_cmd,
    output logic           busy
);
    import osct_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_src = RD_LEAF;
        busy    = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.cap = 1'b1;
                    n_state = (i_op == OP_QUERY) ? S_QRY_ROOT : S_INS_LEAF;
                end
            end
            S_INS_LEAF: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_LEAF;
                n_state = S_INS_CHK;
            end
            S_INS_CHK: begin
                // already marked: nothing to update
                if (i_stat.leaf_set) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = RD_PATH;
                    o_cmd.lvl_inc = 1'b1;
                    n_state = S_INS_UPD;
                end
            end
            S_INS_UPD: begin
                // write back the node read last cycle, read the next level down
                o_cmd.inc_wr = 1'b1;
                if (i_stat.lvl_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = RD_PATH;
                    o_cmd.lvl_inc = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_QRY_ROOT: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_ROOT;
                n_state = S_QRY_CHK;
            end
            S_QRY_CHK: begin
                if (i_stat.root_bad) begin
                    o_cmd.res_err = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_CHILD;
                    n_state = S_QRY_WALK;
                end
            end
            S_QRY_WALK: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.lvl_inc   = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.res_ok = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_NEXT;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/osct_dpath.sv @@
module osct_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  osct_pkg::t_item   i_item,
    input  osct_pkg::t_cmd    i_cmd,
    output osct_pkg::t_stat   o_stat,
    output osct_pkg::t_result o_result,
    output logic              o_result_valid
);
    import osct_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [RANK_W-1:0] r_rank;
    logic [ADDR_W-1:0] r_node;
    logic [LVL_W-1:0]  r_level;
    logic [ADDR_W-1:0] r_raddr;
    logic [ADDR_W-1:0] r_clr_addr;
    t_result           r_result;
    logic              r_valid;

    logic [RANK_W-1:0] n_rank;
    logic [ADDR_W-1:0] n_node;
    logic [ADDR_W-1:0] leaf_addr;
    logic [ADDR_W-1:0] path_addr;
    logic [LVL_W-1:0]  shamt;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [CNT_W-1:0]  rd_data;
    logic              go_left;

    // Count store
    osct_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Node on the insert path at the current level
    assign leaf_addr = {1'b1, r_pos};
    assign shamt     = LVL_W'(LEVELS) - r_level;
    assign path_addr = leaf_addr >> shamt;

    // Descent step: left subtree holds enough marks or not
    assign go_left = (rd_data >= r_rank);
    assign n_node  = {r_node[ADDR_W-2:0], ~go_left};
    assign n_rank  = go_left ? r_rank : (r_rank - rd_data);

    // Read address select
    always_comb begin
        case (i_cmd.rd_src)
            RD_LEAF:  rd_addr = leaf_addr;
            RD_PATH:  rd_addr = path_addr;
            RD_ROOT:  rd_addr = ADDR_W'(1);
            RD_CHILD: rd_addr = {r_node[ADDR_W-2:0], 1'b0};
            RD_NEXT:  rd_addr = {n_node[ADDR_W-2:0], 1'b0};
            default:  rd_addr = leaf_addr;
        endcase
    end

    // Write port: clearing sweep or count increment
    assign we    = i_cmd.clr_wr | i_cmd.inc_wr;
    assign waddr = i_cmd.clr_wr ? r_clr_addr : r_raddr;
    assign wdata = i_cmd.clr_wr ? '0 : (rd_data + CNT_W'(1));

    // Status back to the controller
    assign o_stat.clr_last  = &r_clr_addr;
    assign o_stat.leaf_set  = (rd_data != '0);
    assign o_stat.root_bad  = (r_rank == '0) || (r_rank > rd_data);
    assign o_stat.lvl_more  = (r_level <= LVL_W'(LEVELS));
    assign o_stat.walk_last = (r_level == LVL_W'(LEVELS - 1));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            r_valid <= i_cmd.res_err | i_cmd.res_ok;
        end
    end

    // Item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pos   <= i_item.position;
            r_rank  <= i_item.rank;
            r_node  <= ADDR_W'(1);
            r_level <= '0;
        end else begin
            if (i_cmd.lvl_inc) begin
                r_level <= r_level + LVL_W'(1);
            end
            if (i_cmd.walk_step) begin
                r_node <= n_node;
                r_rank <= n_rank;
            end
        end
        if (i_cmd.rd_en) begin
            r_raddr <= rd_addr;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_err) begin
            r_result.found_position <= '0;
            r_result.status         <= ST_ERROR;
        end else if (i_cmd.res_ok) begin
            r_result.found_position <= n_node[POS_W-1:0];
            r_result.status         <= ST_FOUND;
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_valid;

endmodule

@@ hdl/order_statistic_count_tree_unit.sv @@
// Order-statistic count tree over positions 0..1023, kept as subtree counts in
// one 2048 x 11 RAM (root at address 1). Pulse start while busy is low to
// transfer one command: an insert marks a position (no result; marking twice
// changes nothing), a query returns the rank-th smallest marked position. The
// single RAM read port sets the pace, one tree level per cycle: an insert only
// reads the leaf when the position is already marked, and otherwise increments
// every count from the root down to the leaf; a query stops after the root read
// on a bad rank (zero or above the marked count) and otherwise walks down to a
// leaf. Each query result is shown on o_result for one cycle with o_result_valid
// high, in the same cycle as busy falls; it cannot be held off. After reset, busy
// stays high while the count RAM is swept to zero.
module order_statistic_count_tree_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  osct_pkg::t_item   i_item,
    output logic              busy,
    output osct_pkg::t_result o_result,
    output logic              o_result_valid
);
    import osct_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    osct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_item.operation),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    osct_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // Accepted command always occupies the unit in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer not followed by busy");

    // Error results carry position zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == ST_ERROR)) |->
        (o_result.found_position == '0))
        else $error("error result with nonzero position");

    // Results never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    // Clearing sweep and item writes never coincide
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.clr_wr && cmd.inc_wr))
        else $error("clear and increment write in the same cycle");

endmodule
